FILE: design/tn_neg_pkg.sv
// Shared types, codes and lookup functions for the telnet option negotiator.
package tn_neg_pkg;

  // Subnegotiation buffer
  localparam int SUB_DEPTH = 32;
  localparam int SB_AW     = $clog2(SUB_DEPTH);
  localparam logic [SB_AW-1:0] SB_LEN_MAX    = SB_AW'(SUB_DEPTH - 1);
  localparam logic [SB_AW-1:0] NAWS_LAST_IDX = SB_AW'(4);
  localparam logic [SB_AW-1:0] NAME_FIRST    = SB_AW'(2);

  // Result budget of one input beat
  localparam int MAX_RES = 32;
  localparam int RES_W   = $clog2(MAX_RES + 1);
  localparam logic [RES_W-1:0] RES_LIMIT = RES_W'(MAX_RES);
  localparam logic [RES_W-1:0] RES_FIT3  = RES_W'(MAX_RES - 3);

  // Option table
  localparam int OPT_N  = 256;
  localparam int OPT_AW = $clog2(OPT_N);

  // Telnet commands
  localparam logic [7:0] C_SE   = 8'd240;
  localparam logic [7:0] C_NOP  = 8'd241;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_IAC  = 8'd255;

  // Telnet options
  localparam logic [7:0] O_ECHO     = 8'd1;
  localparam logic [7:0] O_SGA      = 8'd3;
  localparam logic [7:0] O_TTYPE    = 8'd24;
  localparam logic [7:0] O_NAWS     = 8'd31;
  localparam logic [7:0] O_LINEMODE = 8'd34;
  localparam logic [7:0] O_NEWENV   = 8'd39;
  localparam logic [7:0] TTYPE_SEND = 8'd1;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WIN  = 2'd1;
  localparam logic [1:0] KIND_NAME = 2'd2;

  // Reply script steps: IAC cmd opt, then the terminal-type request
  localparam logic [3:0] STEP_FIRST    = 4'd0;
  localparam logic [3:0] STEP_LAST_NOP = 4'd1;
  localparam logic [3:0] STEP_LAST_CMD = 4'd2;
  localparam logic [3:0] STEP_ASK      = 4'd3;
  localparam logic [3:0] STEP_LAST_ASK = 4'd8;

  // Policy or last-sent code: zero for none, else {1, low two bits of the command}
  localparam logic [2:0] POL_NONE = 3'b000;

  localparam logic [1:0] FIN_DONE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_OPT
  } ph_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPT_CHK,
    S_SE_HEAD,
    S_NW_RD,
    S_NW_DAT,
    S_NW_PUSH,
    S_NM_RD,
    S_NM_DAT,
    S_AN_RD,
    S_AN_CHK,
    S_AN_NXT,
    S_EMIT,
    S_FLUSH
  } st_t;

  typedef struct packed {
    logic [2:0] peer_pol;
    logic [2:0] loc_pol;
    logic [2:0] do_sent;
    logic [2:0] will_sent;
  } opt_ent_t;

  localparam int OPT_ENT_W = $bits(opt_ent_t);

  function automatic logic [2:0] pol_of(input logic [7:0] cmd);
    return {1'b1, cmd[1:0]};
  endfunction

  // WILL differs from the other three commands above its low two bits
  function automatic logic [7:0] cmd_of(input logic [2:0] pol);
    logic [7:0] c;
    case (pol[1:0])
      C_WILL[1:0]: c = C_WILL;
      C_WONT[1:0]: c = C_WONT;
      C_DO[1:0]:   c = C_DO;
      default:     c = C_DONT;
    endcase
    return c;
  endfunction

  // DO and DONT share one last-sent table, WILL and WONT the other
  function automatic logic is_do_pol(input logic [2:0] pol);
    return pol[1] ^ pol[0];
  endfunction

  function automatic opt_ent_t reset_entry(input logic [7:0] opt);
    opt_ent_t e;
    e = '0;
    case (opt)
      O_ECHO: begin
        e.peer_pol = pol_of(C_DO);
        e.loc_pol  = pol_of(C_WONT);
      end
      O_SGA: begin
        e.peer_pol = pol_of(C_DO);
        e.loc_pol  = pol_of(C_WILL);
      end
      O_NAWS:     e.peer_pol = pol_of(C_DO);
      O_TTYPE:    e.peer_pol = pol_of(C_DO);
      O_LINEMODE: e.peer_pol = pol_of(C_DONT);
      O_NEWENV: begin
        e.peer_pol = pol_of(C_DO);
        e.loc_pol  = pol_of(C_WONT);
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] script_byte(input logic [3:0] step, input logic [7:0] cmd,
                                             input logic [7:0] opt);
    logic [7:0] b;
    case (step)
      4'd0:    b = C_IAC;
      4'd1:    b = cmd;
      4'd2:    b = opt;
      4'd3:    b = C_IAC;
      4'd4:    b = C_SB;
      4'd5:    b = O_TTYPE;
      4'd6:    b = TTYPE_SEND;
      4'd7:    b = C_IAC;
      4'd8:    b = C_SE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/telnet_option_negotiator_top.sv
// Top level of the telnet option negotiator: parser, sequencer, tables and output stage.
// Throughput: one input beat at a time; in_stall holds the next beat off until the
//   sequencer is back in idle. An announce walks up to 512 table entries, over both passes,
//   through the single read port of the option table.
// Reset: per-entry valid bits supply the option presets, the buffer is not cleared.
module telnet_option_negotiator_top
  import tn_neg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_window_width,
  output logic [15:0] out_window_height,
  output logic        out_negotiation_done,
  output logic        out_last
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  st_t              st_r, st_nxt;
  ph_t              phase_r, phase_nxt;
  logic [1:0]       pend_cmd_r, pend_cmd_nxt;   // low bits of the pending DO/DONT/WILL/WONT
  logic             sub_mode_r, sub_mode_nxt;
  logic [SB_AW-1:0] sub_len_r, sub_len_nxt;
  logic [1:0]       fin_r, fin_nxt;
  logic [OPT_N-1:0] tbl_vld_r;

  // Sequencer working registers
  logic [SB_AW-1:0]  idx_r, idx_nxt;            // buffer walk index
  logic [OPT_AW-1:0] an_idx_r, an_idx_nxt;      // announce walk index
  logic              an_pass_r, an_pass_nxt;    // 0 = local table, 1 = peer table
  logic [RES_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [3:0]        seq_step_r, seq_step_nxt;
  logic [3:0]        seq_end_r, seq_end_nxt;
  logic [7:0]        seq_cmd_r, seq_cmd_nxt;
  logic [7:0]        seq_opt_r, seq_opt_nxt;
  logic              seq_an_r, seq_an_nxt;

  // Read-side tracking of the option table
  logic [OPT_AW-1:0] rd_opt_r;
  logic              rd_vld_r;

  // One-deep hold stage ahead of the output register: a result waits here until
  // the next one, or the end of the beat, tells whether it is the last.
  logic        pend_v_r, pend_v_nxt;
  logic [1:0]  pend_kind_r, pend_kind_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic [15:0] pend_w_r, pend_w_nxt;
  logic [15:0] pend_h_r, pend_h_nxt;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_w_r;
  logic [15:0] out_h_r;
  logic        out_done_r;
  logic        out_last_r;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                 buf_we, buf_re;
  logic [SB_AW-1:0]     buf_waddr, buf_raddr;
  logic [7:0]           buf_wdata, buf_rdata;
  logic                 tbl_we, tbl_re;
  logic [OPT_AW-1:0]    tbl_waddr, tbl_raddr;
  logic [OPT_ENT_W-1:0] tbl_wdata, tbl_rdata;

  tn_neg_ram #(
    .WIDTH (8),
    .DEPTH (SUB_DEPTH)
  ) u_sub_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // Each entry holds both policies and both last-sent codes of one option
  tn_neg_ram #(
    .WIDTH (OPT_ENT_W),
    .DEPTH (OPT_N)
  ) u_opt_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic       can_load, push_ok, push, mv, mv_last;
  logic [1:0] push_kind;
  logic [7:0] push_byte;
  logic [15:0] push_w, push_h;
  opt_ent_t   ent, upd;
  logic [2:0] pol;
  logic       sent_hit, send_c, ask_c;

  // Entries never written read as their preset value
  assign ent      = rd_vld_r ? opt_ent_t'(tbl_rdata) : reset_entry(rd_opt_r);
  assign can_load = !out_valid_r || !out_stall;
  assign push_ok  = !pend_v_r || can_load;
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    st_nxt       = st_r;
    phase_nxt    = phase_r;
    pend_cmd_nxt = pend_cmd_r;
    sub_mode_nxt = sub_mode_r;
    sub_len_nxt  = sub_len_r;
    fin_nxt      = fin_r;
    idx_nxt      = idx_r;
    an_idx_nxt   = an_idx_r;
    an_pass_nxt  = an_pass_r;
    res_cnt_nxt  = res_cnt_r;
    acc_nxt      = acc_r;
    seq_step_nxt = seq_step_r;
    seq_end_nxt  = seq_end_r;
    seq_cmd_nxt  = seq_cmd_r;
    seq_opt_nxt  = seq_opt_r;
    seq_an_nxt   = seq_an_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_byte_nxt = pend_byte_r;
    pend_w_nxt    = pend_w_r;
    pend_h_nxt    = pend_h_r;

    buf_we    = 1'b0;
    buf_waddr = sub_len_r;
    buf_wdata = in_rx_byte;
    buf_re    = 1'b0;
    buf_raddr = idx_r;
    tbl_we    = 1'b0;
    tbl_waddr = rd_opt_r;
    tbl_re    = 1'b0;
    tbl_raddr = an_idx_r;

    push      = 1'b0;
    push_kind = KIND_TX;
    push_byte = 8'h00;
    push_w    = 16'h0000;
    push_h    = 16'h0000;
    mv        = 1'b0;
    mv_last   = 1'b0;

    upd      = ent;
    pol      = POL_NONE;
    sent_hit = 1'b0;
    send_c   = 1'b0;
    ask_c    = 1'b0;

    case (st_r)
      S_IDLE: begin
        // finished: take the beat and drop it
        if (in_valid && !fin_r[1]) begin
          if (in_op) begin
            an_idx_nxt  = '0;
            an_pass_nxt = 1'b0;
            res_cnt_nxt = '0;
            st_nxt      = S_AN_RD;
          end else begin
            case (phase_r)
              PH_CMD: begin
                phase_nxt = PH_IDLE;
                case (in_rx_byte)
                  C_SE: begin
                    sub_mode_nxt = 1'b0;
                    // an empty buffer has a zero head: nothing to report
                    if (sub_len_r != '0) begin
                      buf_re    = 1'b1;
                      buf_raddr = '0;
                      st_nxt    = S_SE_HEAD;
                    end
                  end
                  C_NOP: begin
                    seq_step_nxt = STEP_FIRST;
                    seq_end_nxt  = STEP_LAST_NOP;
                    seq_cmd_nxt  = C_NOP;
                    seq_an_nxt   = 1'b0;
                    st_nxt       = S_EMIT;
                  end
                  C_WILL, C_WONT, C_DO, C_DONT: begin
                    pend_cmd_nxt = in_rx_byte[1:0];
                    phase_nxt    = PH_OPT;
                  end
                  C_SB: begin
                    sub_mode_nxt = 1'b1;
                    sub_len_nxt  = '0;
                  end
                  C_IAC: fin_nxt = FIN_DONE;
                  default: ;
                endcase
              end
              PH_OPT: begin
                phase_nxt = PH_IDLE;
                tbl_re    = 1'b1;
                tbl_raddr = in_rx_byte;
                st_nxt    = S_OPT_CHK;
              end
              default: begin
                if (in_rx_byte == C_IAC) begin
                  phase_nxt = PH_CMD;
                end else if (sub_mode_r && (sub_len_r < SB_LEN_MAX)) begin
                  buf_we      = 1'b1;
                  sub_len_nxt = sub_len_r + 1'b1;
                end
              end
            endcase
          end
        end
      end

      S_OPT_CHK: begin
        // WILL/WONT consult the peer table, DO/DONT the local one
        if (!(pend_cmd_r[1] ^ pend_cmd_r[0])) begin
          pol = (ent.peer_pol == POL_NONE) ? pol_of(C_WONT) : ent.peer_pol;
          upd.peer_pol = pol;
        end else begin
          pol = (ent.loc_pol == POL_NONE) ? pol_of(C_DONT) : ent.loc_pol;
          upd.loc_pol = pol;
        end
        sent_hit = is_do_pol(pol) ? (ent.do_sent == pol) : (ent.will_sent == pol);
        send_c   = !sent_hit;
        if (send_c) begin
          if (is_do_pol(pol)) begin
            upd.do_sent = pol;
          end else begin
            upd.will_sent = pol;
          end
        end
        ask_c     = (pend_cmd_r == C_WILL[1:0]) && (rd_opt_r == O_TTYPE);
        tbl_we    = 1'b1;
        tbl_waddr = rd_opt_r;
        seq_cmd_nxt  = cmd_of(pol);
        seq_opt_nxt  = rd_opt_r;
        seq_step_nxt = send_c ? STEP_FIRST : STEP_ASK;
        seq_end_nxt  = ask_c ? STEP_LAST_ASK : STEP_LAST_CMD;
        seq_an_nxt   = 1'b0;
        st_nxt       = (send_c || ask_c) ? S_EMIT : S_FLUSH;
      end

      S_SE_HEAD: begin
        if (buf_rdata == O_TTYPE) begin
          fin_nxt     = fin_r + 2'd1;
          idx_nxt     = NAME_FIRST;
          res_cnt_nxt = '0;
          st_nxt      = S_NM_RD;
        end else if (buf_rdata == O_NAWS) begin
          fin_nxt = fin_r + 2'd1;
          idx_nxt = SB_AW'(1);
          st_nxt  = S_NW_RD;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      S_NW_RD: begin
        buf_re    = 1'b1;
        buf_raddr = idx_r;
        st_nxt    = S_NW_DAT;
      end

      S_NW_DAT: begin
        // bytes past the stored length count as zero
        acc_nxt = {acc_r[23:0], (idx_r < sub_len_r) ? buf_rdata : 8'h00};
        idx_nxt = idx_r + 1'b1;
        st_nxt  = (idx_r == NAWS_LAST_IDX) ? S_NW_PUSH : S_NW_RD;
      end

      S_NW_PUSH: begin
        if (push_ok) begin
          push      = 1'b1;
          push_kind = KIND_WIN;
          push_w    = acc_r[31:16];
          push_h    = acc_r[15:0];
          st_nxt    = S_FLUSH;
        end
      end

      S_NM_RD: begin
        if ((idx_r < sub_len_r) && (res_cnt_r < RES_LIMIT)) begin
          buf_re    = 1'b1;
          buf_raddr = idx_r;
          st_nxt    = S_NM_DAT;
        end else begin
          st_nxt = S_FLUSH;
        end
      end

      S_NM_DAT: begin
        // a zero byte ends the name
        if (buf_rdata == 8'h00) begin
          st_nxt = S_FLUSH;
        end else if (push_ok) begin
          push        = 1'b1;
          push_kind   = KIND_NAME;
          push_byte   = buf_rdata;
          res_cnt_nxt = res_cnt_r + 1'b1;
          idx_nxt     = idx_r + 1'b1;
          st_nxt      = S_NM_RD;
        end
      end

      S_AN_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = an_idx_r;
        st_nxt    = S_AN_CHK;
      end

      S_AN_CHK: begin
        pol      = an_pass_r ? ent.peer_pol : ent.loc_pol;
        sent_hit = is_do_pol(pol) ? (ent.do_sent == pol) : (ent.will_sent == pol);
        // a command that does not fit whole is skipped and leaves its entry alone
        if ((pol != POL_NONE) && !sent_hit && (res_cnt_r <= RES_FIT3)) begin
          if (is_do_pol(pol)) begin
            upd.do_sent = pol;
          end else begin
            upd.will_sent = pol;
          end
          tbl_we       = 1'b1;
          tbl_waddr    = rd_opt_r;
          res_cnt_nxt  = res_cnt_r + RES_W'(3);
          seq_cmd_nxt  = cmd_of(pol);
          seq_opt_nxt  = rd_opt_r;
          seq_step_nxt = STEP_FIRST;
          seq_end_nxt  = STEP_LAST_CMD;
          seq_an_nxt   = 1'b1;
          st_nxt       = S_EMIT;
        end else begin
          st_nxt = S_AN_NXT;
        end
      end

      S_AN_NXT: begin
        // once no further command fits, the rest of the walk changes nothing
        if (res_cnt_r > RES_FIT3) begin
          st_nxt = S_FLUSH;
        end else if (&an_idx_r) begin
          if (an_pass_r) begin
            st_nxt = S_FLUSH;
          end else begin
            an_pass_nxt = 1'b1;
            an_idx_nxt  = '0;
            st_nxt      = S_AN_RD;
          end
        end else begin
          an_idx_nxt = an_idx_r + 1'b1;
          st_nxt     = S_AN_RD;
        end
      end

      S_EMIT: begin
        if (push_ok) begin
          push         = 1'b1;
          push_kind    = KIND_TX;
          push_byte    = script_byte(seq_step_r, seq_cmd_r, seq_opt_r);
          seq_step_nxt = seq_step_r + 4'd1;
          if (seq_step_r == seq_end_r) begin
            st_nxt = seq_an_r ? S_AN_NXT : S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        // release the held result as the last one of the beat
        if (!pend_v_r) begin
          st_nxt = S_IDLE;
        end else if (can_load) begin
          mv         = 1'b1;
          mv_last    = 1'b1;
          pend_v_nxt = 1'b0;
          st_nxt     = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    tbl_wdata = upd;

    // a new result pushes the held one on, which is then known not to be last
    if (push) begin
      mv            = pend_v_r;
      mv_last       = 1'b0;
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = push_kind;
      pend_byte_nxt = push_byte;
      pend_w_nxt    = push_w;
      pend_h_nxt    = push_h;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      pend_cmd_r  <= '0;
      sub_mode_r  <= 1'b0;
      sub_len_r   <= '0;
      fin_r       <= '0;
      tbl_vld_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      phase_r    <= phase_nxt;
      pend_cmd_r <= pend_cmd_nxt;
      sub_mode_r <= sub_mode_nxt;
      sub_len_r  <= sub_len_nxt;
      fin_r      <= fin_nxt;
      pend_v_r   <= pend_v_nxt;
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= 1'b1;
      end
      if (mv) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers: no reset needed
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    an_idx_r    <= an_idx_nxt;
    an_pass_r   <= an_pass_nxt;
    res_cnt_r   <= res_cnt_nxt;
    acc_r       <= acc_nxt;
    seq_step_r  <= seq_step_nxt;
    seq_end_r   <= seq_end_nxt;
    seq_cmd_r   <= seq_cmd_nxt;
    seq_opt_r   <= seq_opt_nxt;
    seq_an_r    <= seq_an_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_w_r    <= pend_w_nxt;
    pend_h_r    <= pend_h_nxt;
    // track which entry is in the read register and whether it was ever written;
    // a write always lands before the next read of any entry is issued
    if (tbl_re) begin
      rd_opt_r <= tbl_raddr;
      rd_vld_r <= tbl_vld_r[tbl_raddr];
    end
    if (mv) begin
      out_kind_r <= pend_kind_r;
      out_byte_r <= pend_byte_r;
      out_w_r    <= pend_w_r;
      out_h_r    <= pend_h_r;
      out_done_r <= fin_r[1];
      out_last_r <= mv_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_byte             = out_byte_r;
  assign out_window_width     = out_w_r;
  assign out_window_height    = out_h_r;
  assign out_negotiation_done = out_done_r;
  assign out_last             = out_last_r;

endmodule

FILE: design/tn_neg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tn_neg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sim/tn_reply_checker.sv
// Reply checker: predicts the negotiator's replies from input beats and compares each one.
module tn_reply_checker
  import tn_neg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic [15:0] out_window_width,
  input  logic [15:0] out_window_height,
  input  logic        out_negotiation_done,
  input  logic        out_last,
  output int          mismatches,
  output int          replies_waiting
);

  localparam logic [7:0] NO_CMD = 8'h00;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] width;
    logic [15:0] height;
    logic        done;
    logic        last;
  } reply_t;

  reply_t     replies_due[$];
  reply_t     beat_replies[$];
  reply_t     want;

  ph_t        phase;
  logic [7:0] held_cmd;
  logic       sb_open;
  logic [7:0] sb_mem [SUB_DEPTH];
  int         sb_len;
  logic [7:0] peer_pol [OPT_N];
  logic [7:0] local_pol [OPT_N];
  logic [7:0] do_last [OPT_N];
  logic [7:0] will_last [OPT_N];
  int         finish_cnt;
  int         fail_cnt = 0;

  function void load_defaults();
    int o;
    phase      = PH_IDLE;
    held_cmd   = NO_CMD;
    sb_open    = 1'b0;
    sb_len     = 0;
    finish_cnt = 0;
    for (o = 0; o < OPT_N; o++) begin
      peer_pol[o]  = NO_CMD;
      local_pol[o] = NO_CMD;
      do_last[o]   = NO_CMD;
      will_last[o] = NO_CMD;
    end
    local_pol[O_ECHO]   = C_WONT;
    local_pol[O_SGA]    = C_WILL;
    local_pol[O_NEWENV] = C_WONT;
    peer_pol[O_ECHO]     = C_DO;
    peer_pol[O_SGA]      = C_DO;
    peer_pol[O_NAWS]     = C_DO;
    peer_pol[O_TTYPE]    = C_DO;
    peer_pol[O_LINEMODE] = C_DONT;
    peer_pol[O_NEWENV]   = C_DO;
  endfunction

  function void add_reply(logic [1:0] kind, logic [7:0] data, logic [15:0] w, logic [15:0] h);
    reply_t r;
    if (beat_replies.size() >= MAX_RES) return;
    r.kind   = kind;
    r.data   = data;
    r.width  = w;
    r.height = h;
    r.done   = 1'b0;
    r.last   = 1'b0;
    beat_replies.push_back(r);
  endfunction

  // Drop a DO/DONT or WILL/WONT that repeats the last one sent, and any command that
  // does not fit whole into the beat's reply budget.
  function void answer(logic [7:0] cmd, logic [7:0] opt);
    if (cmd == C_DO || cmd == C_DONT) begin
      if (do_last[opt] == cmd || beat_replies.size() + 3 > MAX_RES) return;
      do_last[opt] = cmd;
    end else if (cmd == C_WILL || cmd == C_WONT) begin
      if (will_last[opt] == cmd || beat_replies.size() + 3 > MAX_RES) return;
      will_last[opt] = cmd;
    end else begin
      if (beat_replies.size() + 2 > MAX_RES) return;
      add_reply(KIND_TX, C_IAC, '0, '0);
      add_reply(KIND_TX, cmd, '0, '0);
      return;
    end
    add_reply(KIND_TX, C_IAC, '0, '0);
    add_reply(KIND_TX, cmd, '0, '0);
    add_reply(KIND_TX, opt, '0, '0);
  endfunction

  function logic [7:0] sb_peek(int i);
    if (i >= sb_len || i >= SUB_DEPTH) return 8'h00;
    return sb_mem[i];
  endfunction

  function void close_sub();
    logic [7:0] head;
    int         i;
    head    = sb_peek(0);
    sb_open = 1'b0;
    if (head == O_TTYPE) begin
      for (i = 2; i < sb_len && i < SUB_DEPTH && beat_replies.size() < MAX_RES; i++) begin
        if (sb_peek(i) == 8'h00) break;
        add_reply(KIND_NAME, sb_peek(i), '0, '0);
      end
      if (finish_cnt < FIN_DONE) finish_cnt++;
    end else if (head == O_NAWS) begin
      add_reply(KIND_WIN, 8'h00, {sb_peek(1), sb_peek(2)}, {sb_peek(3), sb_peek(4)});
      if (finish_cnt < FIN_DONE) finish_cnt++;
    end
  endfunction

  function void take_byte(logic [7:0] b);
    case (phase)
      PH_CMD: begin
        phase = PH_IDLE;
        case (b)
          C_SE:  close_sub();
          C_NOP: answer(C_NOP, 8'h00);
          C_WILL, C_WONT, C_DO, C_DONT: begin
            held_cmd = b;
            phase    = PH_OPT;
          end
          C_SB: begin
            sb_open = 1'b1;
            sb_len  = 0;
          end
          C_IAC:   finish_cnt = FIN_DONE;
          default: ;
        endcase
      end
      PH_OPT: begin
        phase = PH_IDLE;
        if (held_cmd == C_WILL || held_cmd == C_WONT) begin
          if (peer_pol[b] == NO_CMD) peer_pol[b] = C_WONT;
          answer(peer_pol[b], b);
          // an offer of TTYPE is followed by a request for the name
          if (held_cmd == C_WILL && b == O_TTYPE) begin
            add_reply(KIND_TX, C_IAC, '0, '0);
            add_reply(KIND_TX, C_SB, '0, '0);
            add_reply(KIND_TX, O_TTYPE, '0, '0);
            add_reply(KIND_TX, TTYPE_SEND, '0, '0);
            add_reply(KIND_TX, C_IAC, '0, '0);
            add_reply(KIND_TX, C_SE, '0, '0);
          end
        end else begin
          if (local_pol[b] == NO_CMD) local_pol[b] = C_DONT;
          answer(local_pol[b], b);
        end
      end
      default: begin
        if (b == C_IAC) begin
          phase = PH_CMD;
        end else if (sb_open && sb_len < SUB_DEPTH - 1) begin
          sb_mem[sb_len] = b;
          sb_len++;
        end
      end
    endcase
  endfunction

  function void predict_replies(logic op, logic [7:0] b);
    int     o;
    int     k;
    reply_t r;
    if (finish_cnt >= FIN_DONE) return;
    beat_replies.delete();
    if (op) begin
      for (o = 0; o < OPT_N; o++)
        if (local_pol[o] != NO_CMD) answer(local_pol[o], 8'(o));
      for (o = 0; o < OPT_N; o++)
        if (peer_pol[o] != NO_CMD) answer(peer_pol[o], 8'(o));
    end else begin
      take_byte(b);
    end
    for (k = 0; k < beat_replies.size(); k++) begin
      r      = beat_replies[k];
      r.done = (finish_cnt >= FIN_DONE);
      r.last = (k == beat_replies.size() - 1);
      replies_due.push_back(r);
    end
  endfunction

  function int field_miss(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v === got_v) return 0;
    $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      load_defaults();
      replies_due.delete();
    end else begin
      if (in_valid && !in_stall) predict_replies(in_op, in_rx_byte);
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("reply with none due: kind %0d, byte %0d", out_kind, out_byte);
          fail_cnt++;
        end else begin
          want = replies_due.pop_front();
          fail_cnt += field_miss("out_kind", 16'(want.kind), 16'(out_kind));
          fail_cnt += field_miss("out_byte", 16'(want.data), 16'(out_byte));
          fail_cnt += field_miss("out_window_width", want.width, out_window_width);
          fail_cnt += field_miss("out_window_height", want.height, out_window_height);
          fail_cnt += field_miss("out_negotiation_done", 16'(want.done),
                                 16'(out_negotiation_done));
          fail_cnt += field_miss("out_last", 16'(want.last), 16'(out_last));
        end
      end
    end
    mismatches      <= fail_cnt;
    replies_waiting <= replies_due.size();
  end

endmodule

FILE: sim/tb_telnet_option_negotiator_top.sv
// Testbench top: clock, reset, client byte stream and verdict for the telnet option negotiator.
module tb_telnet_option_negotiator_top
  import tn_neg_pkg::*;
;

  // Beat counts that shape the run: random traffic stops at RANDOM_UNTIL, and from
  // CALM_FROM on neither side idles any more.
  localparam int CALM_FROM    = 300;
  localparam int RANDOM_UNTIL = 365;
  // An announce walks up to 512 table entries with no beat moving meanwhile; allow for that.
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        in_op      = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_window_width;
  logic [15:0] out_window_height;
  logic        out_negotiation_done;
  logic        out_last;

  int          mismatches;
  int          replies_waiting;
  bit          calm         = 1'b0;
  int          beats_sent   = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;

  // Shadow of the parser as the client sees it. The stream must not finish negotiation
  // early: a single session is all the run has, since reset comes only once. IAC IAC and
  // an IAC SE that would close a TTYPE or NAWS report are therefore steered away from
  // during random traffic.
  ph_t         trk_phase  = PH_IDLE;
  logic        trk_sb_on  = 1'b0;
  int          trk_len    = 0;
  logic [7:0]  trk_head   = 8'h00;

  initial begin
    forever #5 clk = ~clk;
  end

  telnet_option_negotiator_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_byte             (out_byte),
    .out_window_width     (out_window_width),
    .out_window_height    (out_window_height),
    .out_negotiation_done (out_negotiation_done),
    .out_last             (out_last)
  );

  tn_reply_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_byte             (out_byte),
    .out_window_width     (out_window_width),
    .out_window_height    (out_window_height),
    .out_negotiation_done (out_negotiation_done),
    .out_last             (out_last),
    .mismatches           (mismatches),
    .replies_waiting      (replies_waiting)
  );

  // Receiver: stall in random bursts, none once the run is calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat and hold it until the block takes it; sometimes drop valid for a
  // short burst first so that gaps land on every phase of the block's work.
  task automatic push_beat(input logic op, input logic [7:0] data);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Send one received byte. With steer set, swap any byte that would finish negotiation
  // or turn a subnegotiation into a report; either way, advance the shadow parser.
  task automatic feed(input logic [7:0] raw, input bit steer);
    logic [7:0] b;
    b = raw;
    case (trk_phase)
      PH_CMD: begin
        if (steer && (b == C_IAC || (b == C_SE && trk_len != 0 &&
                                    (trk_head == O_TTYPE || trk_head == O_NAWS))))
          b = C_NOP;
        trk_phase = (b == C_WILL || b == C_WONT || b == C_DO || b == C_DONT) ? PH_OPT
                                                                              : PH_IDLE;
        if (b == C_SB) begin
          trk_sb_on = 1'b1;
          trk_len   = 0;
        end
        if (b == C_SE) trk_sb_on = 1'b0;
      end
      PH_OPT: trk_phase = PH_IDLE;
      default: begin
        if (b == C_IAC) begin
          trk_phase = PH_CMD;
        end else if (trk_sb_on) begin
          // a report head in first place would make the closing IAC SE count
          if (steer && trk_len == 0 && (b == O_TTYPE || b == O_NAWS)) b = b ^ 8'h01;
          if (trk_len == 0) trk_head = b;
          if (trk_len < SUB_DEPTH - 1) trk_len++;
        end
      end
    endcase
    push_beat(1'b0, b);
  endtask

  initial begin
    int         pick;
    int         len;
    int         k;
    int         lull;
    logic [7:0] cmd;
    logic [7:0] opt;

    // Hold reset, then release it for good.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The client asks us to do TTYPE and NAWS and then offers both, so
    // the do-table disagrees with the local policy for two options; the first announce
    // then has 33 bytes to say and must drop the last command whole.
    feed(C_IAC, 1'b0); feed(C_DO, 1'b0);   feed(O_TTYPE, 1'b0);
    feed(C_IAC, 1'b0); feed(C_WILL, 1'b0); feed(O_TTYPE, 1'b0);
    feed(C_IAC, 1'b0); feed(C_DO, 1'b0);   feed(O_NAWS, 1'b0);
    feed(C_IAC, 1'b0); feed(C_WILL, 1'b0); feed(O_NAWS, 1'b0);
    push_beat(1'b1, 8'hFF);
    // Unknown requests at both ends of the option range.
    feed(C_IAC, 1'b0); feed(C_DONT, 1'b0); feed(8'hFF, 1'b0);
    feed(C_IAC, 1'b0); feed(C_WONT, 1'b0); feed(8'h00, 1'b0);
    // Terminal name "vt": the name stops at the zero byte. This report is the first of
    // the two that finish negotiation.
    feed(C_IAC, 1'b0); feed(C_SB, 1'b0); feed(O_TTYPE, 1'b0); feed(8'h00, 1'b0);
    feed(8'h76, 1'b0); feed(8'h74, 1'b0); feed(8'h00, 1'b0);
    feed(C_IAC, 1'b0); feed(C_SE, 1'b0);

    // Random part: mostly well-formed telnet sequences with random content, the rest
    // bare commands, data and noise.
    lull = 0;
    while (beats_sent < RANDOM_UNTIL) begin
      if (lull > 0) lull--;
      else if ($urandom_range(0, 15) == 0) lull = $urandom_range(10, 40);
      calm <= (lull > 0) || (beats_sent >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // option request, half of them on the preset options
        case ($urandom_range(0, 3))
          0:       cmd = C_WILL;
          1:       cmd = C_WONT;
          2:       cmd = C_DO;
          default: cmd = C_DONT;
        endcase
        case ($urandom_range(0, 11))
          0:       opt = O_ECHO;
          1:       opt = O_SGA;
          2:       opt = O_TTYPE;
          3:       opt = O_NAWS;
          4:       opt = O_LINEMODE;
          5:       opt = O_NEWENV;
          default: opt = 8'($urandom_range(0, 255));
        endcase
        feed(C_IAC, 1'b1); feed(cmd, 1'b1); feed(opt, 1'b1);
      end else if (pick < 50) begin
        push_beat(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 58) begin
        feed(C_IAC, 1'b1); feed(C_NOP, 1'b1);
      end else if (pick < 75) begin
        // subnegotiation, now and then long enough to overflow the buffer
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        feed(C_IAC, 1'b1); feed(C_SB, 1'b1);
        for (k = 0; k < len; k++) feed(8'($urandom_range(0, 254)), 1'b1);
        feed(C_IAC, 1'b1); feed(C_SE, 1'b1);
      end else if (pick < 85) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) feed(8'($urandom_range(0, 254)), 1'b1);
      end else if (pick < 93) begin
        // command code the parser does not know
        opt = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 239))
                                          : 8'($urandom_range(242, 249));
        feed(C_IAC, 1'b1); feed(opt, 1'b1);
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) feed(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    // Finish negotiation one of three ways, from an idle parser.
    calm <= 1'b1;
    if (trk_phase == PH_CMD) feed(C_NOP, 1'b1);
    else if (trk_phase == PH_OPT) feed(8'h00, 1'b1);
    pick = $urandom_range(0, 2);
    feed(C_IAC, 1'b0);
    if (pick == 0) begin
      // window size, possibly short so that missing bytes read as zero
      feed(C_SB, 1'b0); feed(O_NAWS, 1'b0);
      len = $urandom_range(0, 5);
      for (k = 0; k < len; k++) feed(8'($urandom_range(0, 254)), 1'b0);
      feed(C_IAC, 1'b0); feed(C_SE, 1'b0);
    end else if (pick == 1) begin
      feed(C_IAC, 1'b0);
    end else begin
      // empty terminal name: no reply, yet it still counts
      feed(C_SB, 1'b0); feed(O_TTYPE, 1'b0); feed(C_IAC, 1'b0); feed(C_SE, 1'b0);
    end
    // Negotiation is over: the block must swallow these without a word.
    push_beat(1'b1, 8'h00);
    feed(C_IAC, 1'b0); feed(C_DO, 1'b0); feed(O_ECHO, 1'b0);
    in_valid <= 1'b0;

    // Drain: wait for every predicted reply, then watch a while for strays.
    @(posedge clk);
    while (replies_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
